FILE: hw/rtl/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants of the merge sorter: value width and the
// request structs of the load and result channels.
// ----------------------------------------------------------------------------
package msort_pkg;

	localparam int unsigned VALUE_BITS = 16;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sample_value;
		logic                         last_item;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sorted_value;
		logic                         end_of_run;
		logic                         overflowed;
	} result_t;

endpackage

FILE: hw/rtl/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter
// Batch sorter: collects signed values into a store and, on the last request
// of a batch, sorts them with a stable bottom-up merge between two banks of
// one memory, then streams them out in ascending order.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------
//  sample   | in  | sample_valid / sample_stall  | sample_value, last_item
//  result   | out | result_valid / result_stall  | sorted_value, end_of_run,
//           |     |                              | overflowed
//
// Loading takes one request per cycle. After the last request of n values the
// merge runs ceil(log2 n) passes; each pass reads every value from memory, then
// compares and writes it back, with a setup state before each pair of runs.
// Each result is then read, loaded and handed over, waiting out result_stall.
// sample_stall is high from the last request until the final result is taken.
// Reset empties the batch; the store itself is not cleared.
// ----------------------------------------------------------------------------
module merge_sorter #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  msort_pkg::sample_t sample,
	output logic               result_valid,
	input  logic               result_stall,
	output msort_pkg::result_t result
);
	import msort_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned PW = CW + 2;
	localparam int unsigned MEM_DEPTH = 2 << AW;

	typedef enum logic [6:0] {
		ST_LOAD    = 7'b0000001,
		ST_RUN     = 7'b0000010,
		ST_RD      = 7'b0000100,
		ST_WR      = 7'b0001000,
		ST_EMIT_RD = 7'b0010000,
		ST_EMIT_LD = 7'b0100000,
		ST_HOLD    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [VALUE_BITS-1:0] mem_q [MEM_DEPTH];
	logic [VALUE_BITS-1:0] rd_l_q, rd_r_q;

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [PW-1:0] n_q, w_q, base_q, k_q;
	logic [PW-1:0] lcur_q, lend_q, rcur_q, rend_q;
	logic          src_q;

	logic          result_valid_q;
	result_t       result_q;

	// Write and read ports
	logic          wr_en;
	logic [AW:0]   wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [AW:0]   ra_l, ra_r;

	logic          accept;
	logic          full;
	logic [CW-1:0] fill_nx;
	logic [PW-1:0] base_w, lend_c, lend_w, rend_c;
	logic          l_left, r_left, take_left;
	logic [PW-1:0] w_nx;

	assign accept  = sample_valid && !sample_stall;
	assign full    = (fill_q == CW'(MAX_ITEMS));
	assign fill_nx = full ? fill_q : fill_q + CW'(1);

	// Bounds of the next run pair, clipped to the batch size
	assign base_w = base_q + w_q;
	assign lend_c = (base_w > n_q) ? n_q : base_w;
	assign lend_w = lend_c + w_q;
	assign rend_c = (lend_w > n_q) ? n_q : lend_w;

	// Stable merge: the left run wins ties
	assign l_left    = (lcur_q != lend_q);
	assign r_left    = (rcur_q != rend_q);
	assign take_left = l_left && (!r_left || ($signed(rd_l_q) <= $signed(rd_r_q)));
	assign w_nx      = w_q << 1;

	always_comb begin
		ra_l = {src_q, lcur_q[AW-1:0]};
		ra_r = {src_q, rcur_q[AW-1:0]};
		if (state_q == ST_EMIT_RD) begin
			ra_l = {src_q, k_q[AW-1:0]};
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {src_q, k_q[AW-1:0]};
		wr_data = take_left ? rd_l_q : rd_r_q;
		case (state_q)
			ST_LOAD: begin
				wr_en   = accept && !full;
				wr_addr = {1'b0, fill_q[AW-1:0]};
				wr_data = sample.sample_value;
			end
			ST_WR: begin
				wr_en   = 1'b1;
				wr_addr = {!src_q, k_q[AW-1:0]};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_l_q <= mem_q[ra_l];
		rd_r_q <= mem_q[ra_r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			fill_q         <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
			src_q          <= 1'b0;
			n_q            <= '0;
			w_q            <= '0;
			base_q         <= '0;
			k_q            <= '0;
			lcur_q         <= '0;
			lend_q         <= '0;
			rcur_q         <= '0;
			rend_q         <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						fill_q <= fill_nx;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (sample.last_item) begin
							n_q    <= PW'(fill_nx);
							w_q    <= PW'(1);
							base_q <= '0;
							k_q    <= '0;
							src_q  <= 1'b0;
							if (fill_nx == CW'(1)) begin
								state_q <= ST_EMIT_RD;
							end else begin
								state_q <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					lcur_q  <= base_q;
					lend_q  <= lend_c;
					rcur_q  <= lend_c;
					rend_q  <= rend_c;
					k_q     <= base_q;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (take_left) begin
						lcur_q <= lcur_q + PW'(1);
					end else begin
						rcur_q <= rcur_q + PW'(1);
					end
					k_q <= k_q + PW'(1);
					if (k_q + PW'(1) == rend_q) begin
						if (rend_q == n_q) begin
							// pass done: result bank becomes the source
							src_q  <= !src_q;
							w_q    <= w_nx;
							base_q <= '0;
							k_q    <= '0;
							if (w_nx >= n_q) begin
								state_q <= ST_EMIT_RD;
							end else begin
								state_q <= ST_RUN;
							end
						end else begin
							base_q  <= rend_q;
							state_q <= ST_RUN;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						if (k_q == n_q - PW'(1)) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + PW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			result_q.sorted_value <= $signed(rd_l_q);
			result_q.end_of_run   <= (k_q == n_q - PW'(1));
			result_q.overflowed   <= ovf_q;
		end
	end

	assign sample_stall = (state_q != ST_LOAD);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Loading and output never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(result_valid && !sample_stall))
		else $error("result offered while loading");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_ITEMS))
		else $error("fill count beyond store depth");

	a_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ((k_q < rend_q) && (l_left || r_left)))
		else $error("merge write outside its run pair");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD) |-> (k_q < n_q))
		else $error("output index beyond batch size");

endmodule

FILE: sim/merge_sorter_checker.sv
// ----------------------------------------------------------------------------
// merge_sorter_checker
// Watches both channels of the merge sorter. It keeps its own copy of the
// batch, produces the ascending sequence with ties in arrival order when the
// last request lands, and compares every taken result against it in order.
// ----------------------------------------------------------------------------
module merge_sorter_checker #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  msort_pkg::sample_t sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  msort_pkg::result_t result,
	output int                 fail_count,
	output int                 pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import msort_pkg::*;

	logic signed [VALUE_BITS-1:0] batch_vals [MAX_ITEMS];
	int unsigned                  batch_fill;
	logic                         batch_dropped;
	result_t                      sorted_due [$];
	int                           errors;

	// stable insertion sort of the batch, then queue one result per value
	task automatic sort_batch();
		int unsigned                  i;
		int unsigned                  j;
		logic signed [VALUE_BITS-1:0] key;
		result_t                      r;
		for (i = 1; i < batch_fill; i++) begin
			key = batch_vals[i];
			j = i;
			while (j > 0 && batch_vals[j-1] > key) begin
				batch_vals[j] = batch_vals[j-1];
				j--;
			end
			batch_vals[j] = key;
		end
		for (i = 0; i < batch_fill; i++) begin
			r.sorted_value = batch_vals[i];
			r.end_of_run   = (i + 1 == batch_fill);
			r.overflowed   = batch_dropped;
			sorted_due.push_back(r);
		end
		batch_fill    = 0;
		batch_dropped = 1'b0;
	endtask

	task automatic load_value(input sample_t s);
		if (batch_fill < MAX_ITEMS) begin
			batch_vals[batch_fill] = s.sample_value;
			batch_fill++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (s.last_item)
			sort_batch();
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (sorted_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: expected none, got value %0d eor %0b ovf %0b",
				$time, got.sorted_value, got.end_of_run, got.overflowed);
		end else begin
			want = sorted_due.pop_front();
			if (got.sorted_value !== want.sorted_value || got.end_of_run !== want.end_of_run
					|| got.overflowed !== want.overflowed) begin
				errors++;
				$display("%0t: result mismatch: expected value %0d eor %0b ovf %0b, got value %0d eor %0b ovf %0b",
					$time, want.sorted_value, want.end_of_run, want.overflowed,
					got.sorted_value, got.end_of_run, got.overflowed);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			batch_fill    = 0;
			batch_dropped = 1'b0;
			errors        = 0;
			sorted_due.delete();
		end else begin
			if (sample_valid && !sample_stall)
				load_value(sample);
			if (result_valid && !result_stall)
				check_result(result);
		end
		fail_count    <= errors;
		pending_count <= sorted_due.size();
	end

endmodule

FILE: sim/merge_sorter_tb.sv
// ----------------------------------------------------------------------------
// merge_sorter_tb
// Drives batches built from short lists of signed values into the merge
// sorter under three idle patterns, including an overflowing batch, and lets
// the checker compare the sorted output stream.
// ----------------------------------------------------------------------------
module merge_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msort_pkg::*;

	localparam int unsigned MAX_ITEMS    = 64;
	localparam int          PHASE_ITEMS  = 120;
	localparam int          DRAIN_CYCLES = 50;

	typedef enum int {
		RUN_UP,
		RUN_DOWN,
		RUN_NOISE,
		RUN_TIES,
		RUN_EDGES
	} run_kind_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	sample_t sample       = '0;
	logic    result_stall = 1'b0;
	logic    sample_stall;
	logic    result_valid;
	result_t result;
	int      fail_count;
	int      pending_count;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_items    = 0;

	merge_sorter #(
		.MAX_ITEMS(MAX_ITEMS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	merge_sorter_checker #(
		.MAX_ITEMS(MAX_ITEMS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one request, held until taken
	task automatic send_request(input logic signed [VALUE_BITS-1:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= '{sample_value: v, last_item: last};
		do @(posedge clk); while (sample_stall);
		sent_items++;
	endtask

	// a batch is one or more short lists back to back
	task automatic send_batch(input int size);
		int        left;
		int        run_len;
		int        i;
		int        acc;
		run_kind_t kind;
		logic signed [VALUE_BITS-1:0] v;
		left = size;
		while (left > 0) begin
			run_len = $urandom_range(1, 8);
			if (run_len > left)
				run_len = left;
			kind = run_kind_t'($urandom_range(0, 4));
			acc  = int'($signed(16'($urandom)));
			for (i = 0; i < run_len; i++) begin
				case (kind)
					RUN_UP: begin
						acc = acc + int'($urandom_range(0, 500));
						if (acc > 32767)
							acc = 32767;
						v = 16'(acc);
					end
					RUN_DOWN: begin
						acc = acc - int'($urandom_range(0, 500));
						if (acc < -32768)
							acc = -32768;
						v = 16'(acc);
					end
					RUN_NOISE: v = 16'($urandom);
					RUN_TIES:  v = 16'(int'($urandom_range(0, 6)) - 3);
					default: begin
						case ($urandom_range(0, 3))
							0:       v = 16'sh8000;
							1:       v = 16'sh7fff;
							2:       v = 16'sh0000;
							default: v = 16'shffff;
						endcase
					end
				endcase
				send_request(v, left == 1);
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 71;

		// single-value batch
		send_request(16'sh8000, 1'b1);
		// extremes and ties in one batch
		send_request(16'sh7fff, 1'b0);
		send_request(16'sh8000, 1'b0);
		send_request(16'sh0000, 1'b0);
		send_request(16'shffff, 1'b0);
		send_request(16'sh0001, 1'b0);
		send_request(16'shffff, 1'b0);
		send_request(16'sh7fff, 1'b0);
		send_request(16'sh0000, 1'b1);
		// two equal values
		send_request(16'sh0005, 1'b0);
		send_request(16'sh0005, 1'b1);
		// ascending list followed by a descending one
		send_request(16'sh0001, 1'b0);
		send_request(16'sh0002, 1'b0);
		send_request(16'sh0003, 1'b0);
		send_request(-16'sh0001, 1'b0);
		send_request(-16'sh0002, 1'b0);
		send_request(-16'sh0003, 1'b1);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 71;
					send_batch(MAX_ITEMS);         // exactly full
				end
				1: begin
					send_idle_pct = 71;
					recv_idle_pct = 36;
					send_batch(MAX_ITEMS + 3);     // drops, last request on a full store
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (sent_items < PHASE_ITEMS * (phase + 1) + 17)
				send_batch($urandom_range(1, 20));
			// hold off until the sorter has emptied
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: merge_sorter.f
hw/rtl/msort_pkg.sv
hw/rtl/merge_sorter.sv
sim/merge_sorter_checker.sv
sim/merge_sorter_tb.sv
